// ----- hdl/sliding_window_z_clusterer_macros.svh -----
// assertion macros for the sliding window z clusterer
`ifndef SLIDING_WINDOW_Z_CLUSTERER_MACROS_SVH
`define SLIDING_WINDOW_Z_CLUSTERER_MACROS_SVH
`ifndef SYNTHESIS
`define SWZC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SWZC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SWZC_ASSERT(label, clk, rst, prop, msg)
`define SWZC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- hdl/swzc_pkg.sv -----
// shared types and constants of the sliding window z clusterer
`default_nettype none
package swzc_pkg;

   localparam int TAG_W   = 10;
   localparam int COUNT_W = 10;
   localparam int SIZE_W  = 11;
   localparam int DIST_W  = 20;
   localparam int RUN_W   = 21;
   localparam int IDX_W   = 3;

   localparam logic [RUN_W-1:0]   RUN_CAP   = 21'h1FFFFF;
   localparam logic [COUNT_W-1:0] COUNT_CAP = 10'h3FF;

   typedef enum logic [IDX_W-1:0] {
      CSR_CLUSTER_LENGTH = 3'd0,
      CSR_BREAKING_DIST  = 3'd1,
      CSR_ADDING_DIST    = 3'd2,
      CSR_USE_MAX_GAP    = 3'd3,
      CSR_IGNORE_LEVEL   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [DIST_W-1:0] cluster_length_um;
      logic [DIST_W-1:0] breaking_distance_um;
      logic [DIST_W-1:0] adding_distance_um;
      logic              use_max_gap;
      logic [SIZE_W-1:0] ignore_level;
   } csr_type;

   typedef struct packed {
      logic [TAG_W-1:0]   tag_out;
      logic [COUNT_W-1:0] cluster_number;
      logic               starts_cluster;
      logic               closed_kept;
      logic [SIZE_W-1:0]  closed_size;
      logic               final_kept;
      logic [SIZE_W-1:0]  final_size;
   } rsp_item_type;

endpackage
`default_nettype wire

// ----- hdl/swzc_req_if.sv -----
// track input channel
`default_nettype none
interface swzc_req_if #(
   parameter int Z_WIDTH = 20
) ();
   logic                      valid;
   logic                      ready;
   logic [9:0]                track_tag;
   logic signed [Z_WIDTH-1:0] z0_um;
   logic                      last_in_event;

   modport source (output valid, track_tag, z0_um, last_in_event, input ready);
   modport sink   (input valid, track_tag, z0_um, last_in_event, output ready);
endinterface
`default_nettype wire

// ----- hdl/swzc_rsp_if.sv -----
// cluster result channel
`default_nettype none
interface swzc_rsp_if import swzc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [TAG_W-1:0]   tag_out;
   logic [COUNT_W-1:0] cluster_number;
   logic               starts_cluster;
   logic               closed_kept;
   logic [SIZE_W-1:0]  closed_size;
   logic               final_kept;
   logic [SIZE_W-1:0]  final_size;

   modport source (output valid, tag_out, cluster_number, starts_cluster, closed_kept,
                   closed_size, final_kept, final_size, input ready);
   modport sink   (input valid, tag_out, cluster_number, starts_cluster, closed_kept,
                   closed_size, final_kept, final_size, output ready);
endinterface
`default_nettype wire

// ----- hdl/swzc_csr.sv -----
// configuration registers
`default_nettype none
module swzc_csr import swzc_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic [IDX_W-1:0]  csr_index,
   input  wire logic [DIST_W-1:0] csr_wdata,
   output csr_type                cfg
);

   csr_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CLUSTER_LENGTH: cfg_in.cluster_length_um    = csr_wdata;
            CSR_BREAKING_DIST:  cfg_in.breaking_distance_um = csr_wdata;
            CSR_ADDING_DIST:    cfg_in.adding_distance_um   = csr_wdata;
            CSR_USE_MAX_GAP:    cfg_in.use_max_gap          = csr_wdata[0];
            CSR_IGNORE_LEVEL:   cfg_in.ignore_level         = csr_wdata[SIZE_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cluster_length_um    <= 20'd5000;
         cfg_ff.breaking_distance_um <= 20'd3000;
         cfg_ff.adding_distance_um   <= 20'd100;
         cfg_ff.use_max_gap          <= 1'b0;
         cfg_ff.ignore_level         <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ----- hdl/swzc_core.sv -----
// event state and per-track split decision
`default_nettype none
module swzc_core import swzc_pkg::*; #(
   parameter int MAX_TRACKS = 1024,
   parameter int Z_WIDTH    = 20
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      step_en,
   input  wire logic [TAG_W-1:0]          track_tag,
   input  wire logic signed [Z_WIDTH-1:0] z0_um,
   input  wire logic                      last_in_event,
   input  wire csr_type                   cfg,
   output rsp_item_type                   result
);

   localparam int DW = Z_WIDTH + 1;
   localparam int CW = (Z_WIDTH > RUN_W) ? Z_WIDTH : RUN_W;
   localparam int SIZE_CAP_I = (MAX_TRACKS < 2047) ? MAX_TRACKS : 2047;
   localparam logic [SIZE_W-1:0] SIZE_CAP = SIZE_W'(SIZE_CAP_I);
   localparam logic [CW-1:0] RUN_CAP_C = CW'(RUN_CAP);

   logic               first_ff, first_in;
   logic [Z_WIDTH-1:0] start_z_ff, start_z_in;
   logic [Z_WIDTH-1:0] prev_z_ff, prev_z_in;
   logic [RUN_W-1:0]   run_ff, run_in;
   logic [SIZE_W-1:0]  size_ff, size_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic [Z_WIDTH-1:0] z_u;
   logic [DW-1:0]      gap_diff, gap_neg, span_diff, span_neg;
   logic [Z_WIDTH-1:0] gap_mag, span_mag;
   logic [CW-1:0]      gap_c, span_c, add_c;
   logic [RUN_W-1:0]   gap_sat;
   logic               split;

   assign z_u = z0_um;

   // sign-extended differences, magnitude always fits in Z_WIDTH bits
   assign gap_diff  = {z_u[Z_WIDTH-1], z_u} - {prev_z_ff[Z_WIDTH-1], prev_z_ff};
   assign span_diff = {z_u[Z_WIDTH-1], z_u} - {start_z_ff[Z_WIDTH-1], start_z_ff};
   assign gap_neg   = -gap_diff;
   assign span_neg  = -span_diff;
   assign gap_mag   = gap_diff[DW-1]  ? gap_neg[Z_WIDTH-1:0]  : gap_diff[Z_WIDTH-1:0];
   assign span_mag  = span_diff[DW-1] ? span_neg[Z_WIDTH-1:0] : span_diff[Z_WIDTH-1:0];

   assign gap_c  = CW'(gap_mag);
   assign span_c = CW'(span_mag);
   assign add_c  = cfg.use_max_gap ? CW'(run_ff) : CW'(cfg.adding_distance_um);

   assign split = ((span_c > CW'(cfg.cluster_length_um)) && (gap_c > add_c)) ||
                  (gap_c > CW'(cfg.breaking_distance_um));

   assign gap_sat = (gap_c > RUN_CAP_C) ? RUN_CAP : gap_c[RUN_W-1:0];

   always_comb begin
      first_in   = first_ff;
      start_z_in = start_z_ff;
      prev_z_in  = prev_z_ff;
      run_in     = run_ff;
      size_in    = size_ff;
      count_in   = count_ff;
      result     = '0;
      result.tag_out = track_tag;

      if (first_ff) begin
         count_in   = '0;
         size_in    = SIZE_W'(1);
         start_z_in = z_u;
         run_in     = '0;
         result.starts_cluster = 1'b1;
      end else begin
         if (split) begin
            result.closed_size    = size_ff;
            result.closed_kept    = (size_ff > cfg.ignore_level);
            result.starts_cluster = 1'b1;
            size_in    = SIZE_W'(1);
            start_z_in = z_u;
            if (count_ff != COUNT_CAP) begin
               count_in = count_ff + COUNT_W'(1);
            end
         end else if (size_ff < SIZE_CAP) begin
            size_in = size_ff + SIZE_W'(1);
         end
         // largest gap of the event is tracked in either mode
         if (gap_sat > run_ff) begin
            run_in = gap_sat;
         end
      end
      prev_z_in = z_u;

      if (last_in_event) begin
         result.final_size = size_in;
         result.final_kept = (size_in > cfg.ignore_level);
      end
      first_in = last_in_event;
      result.cluster_number = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff   <= 1'b1;
         start_z_ff <= '0;
         prev_z_ff  <= '0;
         run_ff     <= '0;
         size_ff    <= '0;
         count_ff   <= '0;
      end else if (step_en) begin
         first_ff   <= first_in;
         start_z_ff <= start_z_in;
         prev_z_ff  <= prev_z_in;
         run_ff     <= run_in;
         size_ff    <= size_in;
         count_ff   <= count_in;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/sliding_window_z_clusterer.sv -----
// a track is registered in the input stage, then its result in the output register
// throughput: one track per cycle while results drain; the split decision is combinational
// a stalled result holds in the output register; input stage refills as it drains
// reset: synchronous, active high; config returns to defaults and a new event begins
// reset clears all valid flags; nothing is in flight after reset
`default_nettype none
`include "sliding_window_z_clusterer_macros.svh"
module sliding_window_z_clusterer import swzc_pkg::*; #(
   parameter int MAX_TRACKS = 1024,
   parameter int Z_WIDTH    = 20
) (
   input  wire logic              clock,
   input  wire logic              reset,
   swzc_req_if.sink               req_ch,
   swzc_rsp_if.source             rsp_ch,
   input  wire logic              csr_we,
   input  wire logic [IDX_W-1:0]  csr_index,
   input  wire logic [DIST_W-1:0] csr_wdata
);

   csr_type      cfg;
   rsp_item_type result;

   logic                      s1_valid_ff, s1_valid_in;
   logic [TAG_W-1:0]          s1_tag_ff;
   logic signed [Z_WIDTH-1:0] s1_z_ff;
   logic                      s1_last_ff;
   logic                      out_valid_ff, out_valid_in;
   rsp_item_type              out_ff;
   logic                      out_free, s1_adv, req_xfer;

   swzc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   swzc_core #(
      .MAX_TRACKS (MAX_TRACKS),
      .Z_WIDTH    (Z_WIDTH)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .step_en       (s1_adv),
      .track_tag     (s1_tag_ff),
      .z0_um         (s1_z_ff),
      .last_in_event (s1_last_ff),
      .cfg           (cfg),
      .result        (result)
   );

   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign s1_adv       = s1_valid_ff && out_free;
   assign req_ch.ready = !s1_valid_ff || out_free;
   assign req_xfer     = req_ch.valid && req_ch.ready;

   assign s1_valid_in  = req_xfer || (s1_valid_ff && !s1_adv);
   assign out_valid_in = s1_adv || (out_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_tag_ff  <= req_ch.track_tag;
         s1_z_ff    <= req_ch.z0_um;
         s1_last_ff <= req_ch.last_in_event;
      end
      if (s1_adv) begin
         out_ff <= result;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.tag_out        = out_ff.tag_out;
   assign rsp_ch.cluster_number = out_ff.cluster_number;
   assign rsp_ch.starts_cluster = out_ff.starts_cluster;
   assign rsp_ch.closed_kept    = out_ff.closed_kept;
   assign rsp_ch.closed_size    = out_ff.closed_size;
   assign rsp_ch.final_kept     = out_ff.final_kept;
   assign rsp_ch.final_size     = out_ff.final_size;

   `SWZC_ASSERT_NEXT(a_input_captured, clock, reset, req_xfer, s1_valid_ff, "transfer lost")
   `SWZC_ASSERT_NEXT(a_result_loaded, clock, reset, s1_adv, out_valid_ff, "result lost")
   `SWZC_ASSERT(a_close_on_start, clock, reset,
      !rsp_ch.valid || rsp_ch.closed_size == '0 || rsp_ch.starts_cluster,
      "cluster closed without a new one starting")
   `SWZC_ASSERT(a_final_cap, clock, reset,
      !rsp_ch.valid || rsp_ch.final_size <= SIZE_W'((MAX_TRACKS < 2047) ? MAX_TRACKS : 2047),
      "final size above cap")

endmodule
`default_nettype wire

// ----- tb/tb_sliding_window_z_clusterer.sv -----
`timescale 1ns / 100ps
// self-checking testbench for the sliding window z clusterer with a built-in cluster predictor
module tb_sliding_window_z_clusterer;
   import swzc_pkg::*;

   localparam int MAX_TRACKS     = 1024;
   localparam int Z_W            = 20;
   localparam int Z_MIN          = -(1 << (Z_W - 1));
   localparam int Z_MAX          = (1 << (Z_W - 1)) - 1;
   localparam int SIZE_CAP       = (MAX_TRACKS < 2047) ? MAX_TRACKS : 2047;
   localparam int IDLE_PCT       = 27;
   localparam int LONG_STALL     = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int MAX_REPORTS    = 10;
   localparam int PHASE_TRACKS   = 72;
   localparam int RANDOM_PHASES  = 10;
   localparam int SAT_TRACKS     = 1030;
   localparam int GAP_CLIP       = 20000;

   typedef struct {
      logic [TAG_W-1:0]      tag;
      logic signed [Z_W-1:0] z;
      logic                  ends_event;
   } track_item_type;

   logic              clock;
   logic              reset;
   logic              csr_we;
   logic [IDX_W-1:0]  csr_index;
   logic [DIST_W-1:0] csr_wdata;

   swzc_req_if #(.Z_WIDTH(Z_W)) req_bus ();
   swzc_rsp_if rsp_bus ();

   sliding_window_z_clusterer #(
      .MAX_TRACKS(MAX_TRACKS),
      .Z_WIDTH   (Z_W)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_bus),
      .rsp_ch   (rsp_bus),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // register copies, at their reset values
   logic [DIST_W-1:0] len_um       = 20'd5000;
   logic [DIST_W-1:0] break_um     = 20'd3000;
   logic [DIST_W-1:0] add_um       = 20'd100;
   logic              max_gap_mode = 1'b0;
   logic [SIZE_W-1:0] ignore_lvl   = '0;

   // clustering state of the event in progress
   logic                  new_event   = 1'b1;
   logic signed [Z_W-1:0] start_z     = '0;
   logic signed [Z_W-1:0] last_z      = '0;
   logic [RUN_W-1:0]      widest_gap  = '0;
   logic [SIZE_W-1:0]     open_size   = '0;
   logic [COUNT_W-1:0]    cluster_idx = '0;

   track_item_type pending_tracks[$];
   rsp_item_type   cluster_results_due[$];
   track_item_type offered;
   rsp_item_type   seen;
   rsp_item_type   due;

   int   queued_tracks     = 0;
   int   fail_count        = 0;
   int   quiet_cycles      = 0;
   int   stall_left        = 0;
   logic steady            = 1'b0;
   logic long_stall_wanted = 1'b0;
   logic stall_served      = 1'b0;

   function automatic rsp_item_type assign_to_cluster(input track_item_type trk);
      rsp_item_type res;
      longint gap;
      longint span;
      longint add_lim;
      logic split;
      res = '0;
      res.tag_out = trk.tag;
      if (new_event) begin
         cluster_idx = '0;
         open_size = SIZE_W'(1);
         start_z = trk.z;
         widest_gap = '0;
         res.starts_cluster = 1'b1;
      end else begin
         gap = longint'(trk.z) - longint'(last_z);
         if (gap < 0) gap = -gap;
         span = longint'(trk.z) - longint'(start_z);
         if (span < 0) span = -span;
         add_lim = max_gap_mode ? longint'(widest_gap) : longint'(add_um);
         split = (span > longint'(len_um) && gap > add_lim) || gap > longint'(break_um);
         if (split) begin
            res.closed_size = open_size;
            res.closed_kept = open_size > ignore_lvl;
            open_size = SIZE_W'(1);
            start_z = trk.z;
            if (cluster_idx < COUNT_CAP) cluster_idx = cluster_idx + 1'b1;
            res.starts_cluster = 1'b1;
         end else if (open_size < SIZE_CAP) begin
            open_size = open_size + 1'b1;
         end
         if (gap > longint'(RUN_CAP)) gap = longint'(RUN_CAP);
         if (gap > longint'(widest_gap)) widest_gap = gap[RUN_W-1:0];
      end
      last_z = trk.z;
      if (trk.ends_event) begin
         res.final_size = open_size;
         res.final_kept = open_size > ignore_lvl;
      end
      new_event = trk.ends_event;
      res.cluster_number = cluster_idx;
      return res;
   endfunction

   function automatic string show_result(input rsp_item_type r);
      return $sformatf("tag=%0d num=%0d start=%0b ckept=%0b csize=%0d fkept=%0b fsize=%0d",
                       r.tag_out, r.cluster_number, r.starts_cluster, r.closed_kept,
                       r.closed_size, r.final_kept, r.final_size);
   endfunction

   function automatic logic [DIST_W-1:0] pick_distance(input int typical);
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return DIST_W'($urandom_range(typical));
      endcase
   endfunction

   // gaps scaled to the current thresholds, with some right at them
   function automatic int pick_gap();
      int add_lim;
      int brk_lim;
      add_lim = (add_um > GAP_CLIP) ? GAP_CLIP : int'(add_um);
      brk_lim = (break_um > GAP_CLIP) ? GAP_CLIP : int'(break_um);
      case ($urandom_range(5))
         0: return $urandom_range(3);
         1: return $urandom_range(add_lim + 1);
         2: return $urandom_range(brk_lim + 1);
         3: return $urandom_range(1) ? add_lim + $urandom_range(1) : brk_lim + $urandom_range(1);
         4: return $urandom_range(6000);
         default: return $urandom_range(400000);
      endcase
   endfunction

   task automatic push_track(input logic [TAG_W-1:0] tag, input int z, input logic closes);
      track_item_type trk;
      trk.tag = tag;
      trk.z = z[Z_W-1:0];
      trk.ends_event = closes;
      pending_tracks = {pending_tracks, trk};
      queued_tracks++;
   endtask

   // negative step_lo: scaled random gaps with an occasional step down
   task automatic queue_event(input int n_trk, input logic closes, input int step_lo,
                              input int step_hi);
      int z;
      int step;
      if (step_lo < 0) z = Z_MIN + int'($urandom_range(Z_MAX - Z_MIN));
      else z = Z_MIN + int'($urandom_range(-Z_MIN));
      for (int k = 0; k < n_trk; k++) begin
         if (k != 0) begin
            if (step_lo < 0) step = pick_gap();
            else step = $urandom_range(step_hi, step_lo);
            if (step_lo < 0 && $urandom_range(19) == 0) z = (z - step < Z_MIN) ? Z_MIN : z - step;
            else z = (z + step > Z_MAX) ? Z_MAX : z + step;
         end
         push_track(TAG_W'($urandom), z, closes && (k == n_trk - 1));
      end
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DIST_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_CLUSTER_LENGTH: len_um = value;
         CSR_BREAKING_DIST:  break_um = value;
         CSR_ADDING_DIST:    add_um = value;
         CSR_USE_MAX_GAP:    max_gap_mode = value[0];
         CSR_IGNORE_LEVEL:   ignore_lvl = value[SIZE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic end_writes();
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic program_random_config();
      logic [SIZE_W-1:0] ign;
      case ($urandom_range(3))
         0: ign = '0;
         1: ign = 11'd1024;
         default: ign = SIZE_W'($urandom_range(4));
      endcase
      write_reg(CSR_CLUSTER_LENGTH, pick_distance(8000));
      write_reg(CSR_BREAKING_DIST, pick_distance(5000));
      write_reg(CSR_ADDING_DIST, pick_distance(400));
      write_reg(CSR_USE_MAX_GAP, {(DIST_W - 1)'($urandom), 1'($urandom)});
      write_reg(CSR_IGNORE_LEVEL, {(DIST_W - SIZE_W)'($urandom), ign});
      // indexes past the last register must be ignored
      for (int i = CSR_IGNORE_LEVEL + 1; i < (1 << IDX_W); i++)
         write_reg(IDX_W'(i), DIST_W'($urandom));
      end_writes();
   endtask

   // checked at the falling edge so every update of the rising edge has landed
   task automatic wait_drained();
      while (pending_tracks.size() != 0 || req_bus.valid || cluster_results_due.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // track sender
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            cluster_results_due = {cluster_results_due, assign_to_cluster(offered)};
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_tracks.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
               offered = pending_tracks.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.track_tag <= offered.tag;
               req_bus.z0_um <= offered.z;
               req_bus.last_in_event <= offered.ends_event;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result receiver and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.tag_out = rsp_bus.tag_out;
            seen.cluster_number = rsp_bus.cluster_number;
            seen.starts_cluster = rsp_bus.starts_cluster;
            seen.closed_kept = rsp_bus.closed_kept;
            seen.closed_size = rsp_bus.closed_size;
            seen.final_kept = rsp_bus.final_kept;
            seen.final_size = rsp_bus.final_size;
            if (cluster_results_due.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("%0t: result with nothing pending: %s", $time, show_result(seen));
            end else begin
               due = cluster_results_due.pop_front();
               if (seen !== due) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS)
                     $display("%0t: mismatch\n  expected %s\n  actual   %s", $time,
                              show_result(due), show_result(seen));
               end
            end
         end
         if (long_stall_wanted && !stall_served) begin
            stall_left = LONG_STALL;
            stall_served = 1'b1;
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("FAIL sliding_window_z_clusterer");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.track_tag = '0;
      req_bus.z0_um = '0;
      req_bus.last_in_event = 1'b0;
      rsp_bus.ready = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: lone track event, gaps and spans right at the thresholds,
      // a step down, a last track opening its own cluster, full-range swings
      push_track(10'h000, Z_MIN, 1'b1);
      push_track(10'h3FF, 0, 1'b0);
      push_track(10'h155, 100, 1'b0);
      push_track(10'h2AA, 3100, 1'b0);
      push_track(10'h001, 6101, 1'b0);
      push_track(10'h002, 6201, 1'b0);
      push_track(10'h004, 9101, 1'b0);
      push_track(10'h008, 11101, 1'b0);
      push_track(10'h010, 11202, 1'b0);
      push_track(10'h020, 11302, 1'b0);
      push_track(10'h040, 11000, 1'b0);
      push_track(10'h080, Z_MAX, 1'b1);
      push_track(10'h100, Z_MAX, 1'b0);
      push_track(10'h200, Z_MIN, 1'b1);
      wait_drained();

      // max mode with zero cluster length, singles dropped
      write_reg(CSR_CLUSTER_LENGTH, '0);
      write_reg(CSR_USE_MAX_GAP, 20'd1);
      write_reg(CSR_IGNORE_LEVEL, 20'd1);
      end_writes();
      push_track(10'h0F0, 0, 1'b0);
      push_track(10'h00F, 5, 1'b0);
      push_track(10'h3C3, 8, 1'b0);
      push_track(10'h03C, 20, 1'b0);
      push_track(10'h333, 20, 1'b1);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_drained();
         program_random_config();
         steady = (p == 3);
         queued_tracks = 0;
         while (queued_tracks < PHASE_TRACKS) begin
            if ($urandom_range(9) == 0)
               push_track(TAG_W'($urandom), Z_MIN + int'($urandom_range(Z_MAX - Z_MIN)),
                          1'($urandom));
            else if ($urandom_range(9) == 0)
               queue_event($urandom_range(80, 30), 1'b1, -1, -1);
            else
               queue_event($urandom_range(12, 1), 1'b1, -1, -1);
         end
         // leave an event open so the next settings apply mid-event
         if (p % 2 == 1) queue_event($urandom_range(6, 2), 1'b0, -1, -1);
         if (p == 5) long_stall_wanted = 1'b1;
      end

      // one cluster past the size limit, judged against an ignore level equal to the size cap
      wait_drained();
      write_reg(CSR_CLUSTER_LENGTH, '1);
      write_reg(CSR_BREAKING_DIST, '1);
      write_reg(CSR_ADDING_DIST, '1);
      write_reg(CSR_USE_MAX_GAP, '0);
      write_reg(CSR_IGNORE_LEVEL, 20'd1024);
      end_writes();
      queue_event(SAT_TRACKS, 1'b1, 0, 3);
      queue_event(5, 1'b1, 0, 3);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && cluster_results_due.size() == 0)
         $display("PASS sliding_window_z_clusterer");
      else
         $display("FAIL sliding_window_z_clusterer");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/swzc_pkg.sv
hdl/swzc_req_if.sv
hdl/swzc_rsp_if.sv
hdl/swzc_csr.sv
hdl/swzc_core.sv
hdl/sliding_window_z_clusterer.sv
tb/tb_sliding_window_z_clusterer.sv
